>>> rtl/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;

    localparam int SEM_MAX_WIDTH  = 1024;
    localparam int SEM_MAX_HEIGHT = 1024;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // gradient, square, then one stage per result bit
    localparam int MAG_BITS = 8;
    localparam int LANE_LAT = 2 + MAG_BITS;

    typedef logic [23:0] t_pix;
    typedef logic [7:0]  t_chan;

    typedef struct packed {
        logic row0;   // top row of the window lies above the frame
        logic row2;   // bottom row lies below the frame
        logic col0;   // left column lies before the row start
        logic col2;   // right column lies past the row end
    } t_mask;

endpackage

>>> rtl/sem_ram.sv
`timescale 1ns / 1ps
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sem_lane.sv
`timescale 1ns / 1ps
module sem_lane
    import sem_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_chan i_px [0:8],
    output t_chan o_mag
);
    logic signed [10:0]    p [0:8];
    logic signed [10:0]    n_gx, n_gy;
    logic signed [10:0]    r_gx, r_gy;
    logic signed [21:0]    sq_x, sq_y;
    logic [20:0]           r_s [0:MAG_BITS-1];
    logic [MAG_BITS-1:0]   r_r [0:MAG_BITS];
    logic [MAG_BITS-1:0]   cand [0:MAG_BITS-1];
    logic [2*MAG_BITS-1:0] prod [0:MAG_BITS-1];
    logic [MAG_BITS-1:0]   take;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p[k] = $signed({3'b000, i_px[k]});
        end
        n_gx = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
        n_gy = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end

    assign sq_x = r_gx * r_gx;
    assign sq_y = r_gy * r_gy;

    // bit-serial search for the largest r with r*r - r < s
    always_comb begin
        for (int k = 0; k < MAG_BITS; k++) begin
            cand[k] = r_r[k] | (MAG_BITS'(1) << (MAG_BITS - 1 - k));
            prod[k] = (2*MAG_BITS)'(cand[k]) * (2*MAG_BITS)'(cand[k] - MAG_BITS'(1));
            take[k] = 21'(prod[k]) < r_s[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx   <= n_gx;
            r_gy   <= n_gy;
            r_s[0] <= sq_x[20:0] + sq_y[20:0];
            r_r[0] <= '0;
            for (int k = 0; k < MAG_BITS - 1; k++) begin
                r_s[k+1] <= r_s[k];
            end
            for (int k = 0; k < MAG_BITS; k++) begin
                r_r[k+1] <= take[k] ? cand[k] : r_r[k];
            end
        end
    end

    assign o_mag = r_r[MAG_BITS];
endmodule

>>> rtl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// 3x3 sobel edge magnitude on a raster rgb stream, one request per clock when neither
// side stalls: each request enters a pipeline that advances as a whole and passes the
// line store read, the window update with gradient, the square and 8 root steps. pixels
// outside the frame count as zero; each channel gives the rounded magnitude saturated at
// 255. a pixel's result comes out with the request carrying its lower-right neighbor, so
// after the last pixel of a frame send frame_width + 1 drain requests (cmd = 1) to flush
// the rest; o_frame_end marks the frame's last result, whose request restarts the stream.
// pixel requests after frame end and drains before it are taken and dropped. frame sizes
// are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT; a write to either size register restarts
// the stream.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = SEM_MAX_WIDTH,
    parameter int MAX_HEIGHT = SEM_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    // result out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic                  o_frame_end
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);   // input row runs past the frame on drain

    typedef struct packed {
        logic          valid;
        logic          emit;
        logic          last;
        logic          fwd;
        logic [AW-1:0] addr;
        t_pix          pix;
        t_mask         mask;
    } t_bstage;

    // config registers, raw and clamped
    logic [CFG_DATA_W-1:0] r_fw, r_fh;
    logic [WW-1:0]         wc;
    logic [HW-1:0]         hc;

    // stream counters
    logic [WW-1:0] r_icol, n_icol;
    logic [RW-1:0] r_irow, n_irow;
    logic [WW-1:0] r_ocol, n_ocol;
    logic [HW-1:0] r_orow, n_orow;
    logic          r_frx, n_frx;

    logic    en, acc, take;
    t_pix    pix_in;
    t_bstage r_b, n_b;

    t_pix ram_u_q, ram_m_q, top_d, mid_d;
    t_pix r_prev_mid, r_prev_pix;
    t_pix r_win [0:8];
    t_pix win_s [0:8];
    t_pix px_m  [0:8];

    logic r_vld [0:LANE_LAT-1];
    logic r_lst [0:LANE_LAT-1];

    always_comb begin
        if (r_fw == '0) begin
            wc = WW'(1);
        end else if (int'(r_fw) > MAX_WIDTH) begin
            wc = WW'(MAX_WIDTH);
        end else begin
            wc = WW'(r_fw);
        end
        if (r_fh == '0) begin
            hc = HW'(1);
        end else if (int'(r_fh) > MAX_HEIGHT) begin
            hc = HW'(MAX_HEIGHT);
        end else begin
            hc = HW'(r_fh);
        end
    end

    // whole pipeline moves together; stalls only on a held result
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign acc     = i_valid && en;
    assign take    = acc && ((i_cmd == CMD_DRAIN) ? r_frx : !r_frx);
    assign pix_in  = (i_cmd == CMD_DRAIN) ? '0 : {i_red_in, i_green_in, i_blue_in};

    // front stage: counters, border masks, line store read
    always_comb begin
        logic col_end;
        n_icol = r_icol;
        n_irow = r_irow;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_frx  = r_frx;
        col_end = (r_ocol + WW'(1)) >= wc;

        n_b.valid     = take;
        n_b.emit      = (r_irow >= RW'(2)) || (r_irow == RW'(1) && r_icol != '0);
        n_b.mask.row0 = r_orow == '0;
        n_b.mask.row2 = (RW'(r_orow) + RW'(1)) >= RW'(hc);
        n_b.mask.col0 = r_ocol == '0;
        n_b.mask.col2 = (r_icol == '0) || col_end;
        n_b.last      = n_b.emit && n_b.mask.row2 && col_end;
        n_b.addr      = r_icol[AW-1:0];
        n_b.pix       = pix_in;
        // the request ahead writes this address on the same edge
        n_b.fwd       = r_b.valid && (r_b.addr == r_icol[AW-1:0]);

        if (take) begin
            n_icol = r_icol + WW'(1);
            if (n_icol >= wc) begin
                n_icol = '0;
                n_irow = r_irow + RW'(1);
                if (i_cmd == CMD_PIXEL && n_irow == RW'(hc)) begin
                    n_frx = 1'b1;
                end
            end
            if (n_b.last) begin
                n_icol = '0;
                n_irow = '0;
                n_ocol = '0;
                n_orow = '0;
                n_frx  = 1'b0;
            end else if (n_b.emit) begin
                n_ocol = r_ocol + WW'(1);
                if (col_end) begin
                    n_ocol = '0;
                    n_orow = r_orow + HW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= CFG_DATA_W'(1024);
            r_fh    <= CFG_DATA_W'(1024);
            r_icol  <= '0;
            r_irow  <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_frx   <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH ||
                                  i_cfg_idx == REG_FRAME_HEIGHT)) begin
            if (i_cfg_idx == REG_FRAME_WIDTH) begin
                r_fw <= i_cfg_data;
            end else begin
                r_fh <= i_cfg_data;
            end
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_frx  <= 1'b0;
        end else if (en) begin
            r_icol <= n_icol;
            r_irow <= n_irow;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_frx  <= n_frx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (en) begin
            r_b <= n_b;
        end
    end

    // line stores: upper takes the old middle, middle takes the new pixel
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (en && r_b.valid),
        .i_waddr (r_b.addr),
        .i_wdata (mid_d),
        .i_re    (en),
        .i_raddr (r_icol[AW-1:0]),
        .o_rdata (ram_u_q)
    );

    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (en && r_b.valid),
        .i_waddr (r_b.addr),
        .i_wdata (r_b.pix),
        .i_re    (en),
        .i_raddr (r_icol[AW-1:0]),
        .o_rdata (ram_m_q)
    );

    // bypass when the request ahead wrote the same address, as in single-column frames
    assign top_d = r_b.fwd ? r_prev_mid : ram_u_q;
    assign mid_d = r_b.fwd ? r_prev_pix : ram_m_q;

    always_ff @(posedge i_clk) begin
        if (en && r_b.valid) begin
            r_prev_mid <= mid_d;
            r_prev_pix <= r_b.pix;
        end
    end

    // window shift and border masking
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_s[r*3]     = r_win[r*3+1];
            win_s[r*3+1]   = r_win[r*3+2];
        end
        win_s[2] = top_d;
        win_s[5] = mid_d;
        win_s[8] = r_b.pix;
        for (int r = 0; r < 3; r++) begin
            logic row_out;
            row_out = (r == 0 && r_b.mask.row0) || (r == 2 && r_b.mask.row2);
            px_m[r*3]   = (row_out || r_b.mask.col0) ? '0 : win_s[r*3];
            px_m[r*3+1] = row_out ? '0 : win_s[r*3+1];
            px_m[r*3+2] = (row_out || r_b.mask.col2) ? '0 : win_s[r*3+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH ||
                                      i_cfg_idx == REG_FRAME_HEIGHT))) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (en && r_b.valid) begin
            // frame's last result restarts with an empty window
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= r_b.last ? '0 : win_s[k];
            end
        end
    end

    // one lane per color channel
    t_chan px_r [0:8];
    t_chan px_g [0:8];
    t_chan px_bl [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            px_r[k]  = px_m[k][23:16];
            px_g[k]  = px_m[k][15:8];
            px_bl[k] = px_m[k][7:0];
        end
    end

    sem_lane u_lane_r (.i_clk(i_clk), .i_en(en), .i_px(px_r),  .o_mag(o_red_out));
    sem_lane u_lane_g (.i_clk(i_clk), .i_en(en), .i_px(px_g),  .o_mag(o_green_out));
    sem_lane u_lane_b (.i_clk(i_clk), .i_en(en), .i_px(px_bl), .o_mag(o_blue_out));

    // result valid and frame end ride alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_b.valid && r_b.emit;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lst[0] <= r_b.last;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_lst[k] <= r_lst[k-1];
            end
        end
    end

    assign o_valid     = r_vld[LANE_LAT-1];
    assign o_frame_end = r_lst[LANE_LAT-1];
endmodule
